@@ design/lz_byte_token_decompressor_assert.svh @@
// Assertion macros used by the checker of the byte token decompressor.
`ifndef LZ_BYTE_TOKEN_DECOMPRESSOR_ASSERT_SVH
`define LZ_BYTE_TOKEN_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define LZB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define LZB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lzb_pkg.sv @@
// Types and constants of the byte token decompressor.
package lzb_pkg;

    localparam int DEFAULT_PAGE_BYTES = 65536;

    localparam int DIST_W   = 25;
    localparam int COPY_W   = 13;
    localparam int LEN_W    = 12;
    localparam int OFF_W    = 24;
    localparam int GATHER_W = 32;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [7:0] HDR_LIT_RUN = 8'h80;
    localparam logic [7:0] HDR_REF_A   = 8'hA0;
    localparam logic [7:0] HDR_REF_C   = 8'hC0;
    localparam logic [7:0] HDR_REF_E   = 8'hE0;
    localparam logic [7:0] HDR_REF_F0  = 8'hF0;
    localparam logic [7:0] HDR_REF_F8  = 8'hF8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LIT,
        PH_OPS
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_REFUSED,
        ST_IDLE_STEP,
        ST_BEFORE_START,
        ST_PAGE_FULL
    } status_t;

endpackage

@@ design/lzb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module lzb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lz_byte_token_decompressor.sv @@
// Top level of the byte-oriented LZ page decompressor.
//
// Input channel (in_valid / in_stall): one transfer is either a compressed page
// byte (cmd = byte) or a step that expands one pending back-reference byte.
// first_byte on a compressed byte restarts the page; last_byte marks its end.
// Output channel (res_valid / res_stall): exactly one result per input
// transfer, in order, carrying the decoded byte (if any), its page address,
// the running byte count, parser flags and a status code.
// Throughput is one transfer per cycle, steps included, while the receiver does
// not stall; a distance-one copy runs back to back because the byte written in
// the second stage is forwarded to the history read issued in the same cycle.
// The decode stage issues the history read, the second stage takes the read
// data, writes the history RAM and fills the output register.
// When the receiver stalls, the output register holds its result, the second
// stage keeps its item and the input stalls only once both are full.
// Reset clears the parser, position and pipeline at once; the history RAM is
// not cleared, as it is only ever read below the current write position.
module lz_byte_token_decompressor
    import lzb_pkg::*;
#(
    parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [15:0] out_position,
    output logic [16:0] produced_count,
    output logic        copy_pending,
    output logic        token_open,
    output logic        page_done,
    output logic [2:0]  status
);

    localparam int AW   = $clog2(PAGE_BYTES);
    localparam int WP_W = $clog2(PAGE_BYTES + 1);
    localparam logic [WP_W-1:0] PAGE_WP = WP_W'(PAGE_BYTES);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] off;
    } ref_t;

    function automatic logic [2:0] operand_total(input logic [7:0] h);
        logic [2:0] n;
        if (h < HDR_REF_E)
        begin
            n = 3'd1;
        end
        else if (h < HDR_REF_F0)
        begin
            n = 3'd2;
        end
        else if (h < HDR_REF_F8)
        begin
            n = 3'd3;
        end
        else
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic ref_t decode_ref(input logic [7:0] h, input logic [GATHER_W-1:0] g);
        ref_t r;
        if (h < HDR_REF_C)
        begin
            r.len = LEN_W'(h[2:0]) + LEN_W'(2);
            r.off = OFF_W'({h[4:3], g[7:0]});
        end
        else if (h < HDR_REF_E)
        begin
            r.len = LEN_W'(h[4:0]) + LEN_W'(10);
            r.off = OFF_W'(g[7:0]);
        end
        else if (h < HDR_REF_F0)
        begin
            r.len = LEN_W'(h[3:0]) + LEN_W'(3);
            r.off = OFF_W'(g[15:0]);
        end
        else if (h[3])
        begin
            r.len = LEN_W'({h[2:0], g[7:0]}) + LEN_W'(5);
            r.off = g[31:8];
        end
        else
        begin
            r.len = LEN_W'({h[2:0], g[7:0]}) + LEN_W'(19);
            r.off = OFF_W'(g[23:8]);
        end
        return r;
    endfunction

    // Parser and position state.
    logic [WP_W-1:0]     wp_reg, wp_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic [2:0]          opl_reg, opl_next;
    logic [5:0]          lit_reg, lit_next;
    logic [COPY_W-1:0]   copy_reg, copy_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic                last_reg, last_next;

    // Second stage.
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_emit_reg, s1_emit_next;
    logic          s1_mem_reg, s1_mem_next;
    logic [7:0]    s1_lit_reg;
    logic [AW-1:0] s1_addr_reg, s1_addr_next;
    logic          s1_fwd_reg, s1_fwd_next;
    logic [7:0]    s1_fwd_data_reg;
    logic [16:0]   s1_count_reg, s1_count_next;
    logic          s1_copy_reg, s1_copy_next;
    logic          s1_tok_reg, s1_tok_next;
    logic          s1_done_reg, s1_done_next;
    status_t       s1_status_reg, s1_status_next;

    // Output register.
    logic        res_valid_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_position_reg;
    logic [16:0] produced_count_reg;
    logic        copy_pending_reg;
    logic        token_open_reg;
    logic        page_done_reg;
    status_t     status_reg;

    logic accept, out_free, s1_move;
    logic [7:0] s1_byte;
    logic [7:0] ram_rdata;
    logic [AW-1:0] rd_addr;

    // Effective state after an optional page restart.
    logic                clr;
    logic [WP_W-1:0]     wp_e;
    phase_t              phase_e;
    logic [7:0]          hdr_e;
    logic [GATHER_W-1:0] gather_e, gather_new;
    logic [2:0]          opl_e;
    logic [5:0]          lit_e;
    logic [COPY_W-1:0]   copy_e;
    logic [DIST_W-1:0]   dist_e;
    logic                last_e;
    logic [1:0]          idx;
    logic [WP_W-1:0]     src;
    logic [DIST_W-1:0]   ref_dist;
    ref_t                dec;

    assign out_free = !res_valid_reg || !res_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        clr      = (cmd == CMD_BYTE) && first_byte;
        wp_e     = clr ? '0 : wp_reg;
        phase_e  = clr ? PH_IDLE : phase_reg;
        hdr_e    = clr ? '0 : hdr_reg;
        gather_e = clr ? '0 : gather_reg;
        opl_e    = clr ? '0 : opl_reg;
        lit_e    = clr ? '0 : lit_reg;
        copy_e   = clr ? '0 : copy_reg;
        dist_e   = clr ? '0 : dist_reg;
        last_e   = clr ? 1'b0 : last_reg;

        idx        = 2'(operand_total(hdr_e) - opl_e);
        gather_new = gather_e | (GATHER_W'(data_byte) << {idx, 3'b000});
        dec        = decode_ref(hdr_e, gather_new);
        ref_dist   = DIST_W'(dec.off) + DIST_W'(1);
        src        = wp_e - WP_W'(dist_e);
        rd_addr    = src[AW-1:0];
    end

    // Next state of the parser, position and copy counters.
    always_comb
    begin
        wp_next        = wp_e;
        phase_next     = phase_e;
        hdr_next       = hdr_e;
        gather_next    = gather_e;
        opl_next       = opl_e;
        lit_next       = lit_e;
        copy_next      = copy_e;
        dist_next      = dist_e;
        last_next      = last_e;
        s1_emit_next   = 1'b0;
        s1_mem_next    = 1'b0;
        s1_status_next = ST_OK;

        if (cmd == CMD_STEP)
        begin
            if (copy_e == '0)
            begin
                s1_status_next = ST_IDLE_STEP;
            end
            else
            begin
                if ((DIST_W'(wp_e) >= dist_e) && (wp_e < PAGE_WP))
                begin
                    s1_emit_next = 1'b1;
                    s1_mem_next  = 1'b1;
                    wp_next      = wp_e + WP_W'(1);
                end
                else
                begin
                    s1_status_next = ST_PAGE_FULL;
                end
                copy_next = copy_e - COPY_W'(1);
            end
        end
        else if (copy_e != '0)
        begin
            s1_status_next = ST_REFUSED;
        end
        else
        begin
            if (last_byte)
            begin
                last_next = 1'b1;
            end
            case (phase_e)
                PH_LIT:
                begin
                    if (wp_e < PAGE_WP)
                    begin
                        s1_emit_next = 1'b1;
                        wp_next      = wp_e + WP_W'(1);
                    end
                    else
                    begin
                        s1_status_next = ST_PAGE_FULL;
                    end
                    lit_next = lit_e - 6'd1;
                    if (lit_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_OPS:
                begin
                    gather_next = gather_new;
                    opl_next    = opl_e - 3'd1;
                    if (opl_next == '0)
                    begin
                        phase_next = PH_IDLE;
                        if (ref_dist > DIST_W'(wp_e))
                        begin
                            s1_status_next = ST_BEFORE_START;
                        end
                        else
                        begin
                            dist_next = ref_dist;
                            copy_next = COPY_W'(dec.len);
                        end
                    end
                end
                default:
                begin
                    if (data_byte < HDR_LIT_RUN)
                    begin
                        if (wp_e < PAGE_WP)
                        begin
                            s1_emit_next = 1'b1;
                            wp_next      = wp_e + WP_W'(1);
                        end
                        else
                        begin
                            s1_status_next = ST_PAGE_FULL;
                        end
                    end
                    else if (data_byte < HDR_REF_A)
                    begin
                        lit_next   = 6'(data_byte[4:0]) + 6'd1;
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        hdr_next    = data_byte;
                        gather_next = '0;
                        opl_next    = operand_total(data_byte);
                        phase_next  = PH_OPS;
                    end
                end
            endcase
        end
    end

    // Result flags and second-stage control for the item being accepted.
    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s1_addr_next  = wp_e[AW-1:0];
        s1_count_next = 17'(wp_next);
        s1_copy_next  = copy_next != '0;
        s1_tok_next   = phase_next != PH_IDLE;
        s1_done_next  = last_next && (copy_next == '0) && (phase_next == PH_IDLE);
        // When a new item comes in, a valid emitting second-stage item writes this cycle.
        s1_fwd_next   = s1_valid_reg && s1_emit_reg && (s1_addr_reg == rd_addr);
    end

    always_comb
    begin
        if (!s1_mem_reg)
        begin
            s1_byte = s1_lit_reg;
        end
        else if (s1_fwd_reg)
        begin
            s1_byte = s1_fwd_data_reg;
        end
        else
        begin
            s1_byte = ram_rdata;
        end
    end

    lzb_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_history (
        .clk   (clk),
        .we    (s1_move && s1_emit_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_byte),
        .re    (accept && s1_mem_next),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            phase_reg     <= PH_IDLE;
            hdr_reg       <= '0;
            gather_reg    <= '0;
            opl_reg       <= '0;
            lit_reg       <= '0;
            copy_reg      <= '0;
            dist_reg      <= '0;
            last_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg     <= wp_next;
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                gather_reg <= gather_next;
                opl_reg    <= opl_next;
                lit_reg    <= lit_next;
                copy_reg   <= copy_next;
                dist_reg   <= dist_next;
                last_reg   <= last_next;
            end
            s1_valid_reg <= s1_valid_next;
            if (out_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg     <= s1_emit_next;
            s1_mem_reg      <= s1_mem_next;
            s1_lit_reg      <= data_byte;
            s1_addr_reg     <= s1_addr_next;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_data_reg <= s1_byte;
            s1_count_reg    <= s1_count_next;
            s1_copy_reg     <= s1_copy_next;
            s1_tok_reg      <= s1_tok_next;
            s1_done_reg     <= s1_done_next;
            s1_status_reg   <= s1_status_next;
        end
        if (s1_move)
        begin
            out_valid_reg      <= s1_emit_reg;
            out_byte_reg       <= s1_emit_reg ? s1_byte : 8'd0;
            out_position_reg   <= s1_emit_reg ? 16'(s1_addr_reg) : 16'd0;
            produced_count_reg <= s1_count_reg;
            copy_pending_reg   <= s1_copy_reg;
            token_open_reg     <= s1_tok_reg;
            page_done_reg      <= s1_done_reg;
            status_reg         <= s1_status_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_position   = out_position_reg;
    assign produced_count = produced_count_reg;
    assign copy_pending   = copy_pending_reg;
    assign token_open     = token_open_reg;
    assign page_done      = page_done_reg;
    assign status         = status_reg;

endmodule

@@ design/lzb_checker.sv @@
// Port-level checker for the byte token decompressor and its bind.
`include "lz_byte_token_decompressor_assert.svh"

module lzb_checker
    import lzb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic        out_valid,
    input logic [7:0]  out_byte,
    input logic [15:0] out_position,
    input logic [16:0] produced_count,
    input logic        copy_pending,
    input logic        token_open,
    input logic        page_done,
    input logic [2:0]  status
);

    // A stalled result transfer keeps its payload.
    `LZB_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_byte) && $stable(status) && $stable(produced_count), "stalled result changed")

    // The input only stalls while a finished result is held back.
    `LZB_ASSERT_IMP(a_stall_cause, in_stall, res_valid && res_stall, "input stalled without output back-pressure")

    `LZB_ASSERT_IMP(a_no_byte_zero, res_valid && !out_valid, out_byte == 8'd0 && out_position == 16'd0, "byte fields set without a byte")

    `LZB_ASSERT_IMP(a_done_clean, res_valid && page_done, !copy_pending && !token_open, "page done with work left")

    `LZB_ASSERT_IMP(a_byte_ok, res_valid && out_valid, status == ST_OK, "byte emitted with an error status")

endmodule

bind lz_byte_token_decompressor lzb_checker u_lzb_checker (.*);
